// File: rtl/assert_macros.svh
// Shared assertion macros for the bit timing search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, c, r, ante, cons) \
  label: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, c, r, ante, cons) \
  label: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/cbts_pkg.sv
package cbts_pkg;

  localparam int CLK_W        = 28;
  localparam int RATE_W       = 20;
  localparam int CYC_W        = 14;
  localparam int QUANTA_W     = 5;
  localparam int PROD_W       = CYC_W + QUANTA_W;
  localparam int PRESC_CODE_W = 10;
  localparam int SJW_W        = 2;
  localparam int SEG1_W       = 4;
  localparam int SEG2_W       = 3;

  localparam logic [CLK_W-1:0]  CLK_RESET  = CLK_W'(42000000);
  localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(20000);
  localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(1000000);
  localparam logic [SEG1_W-1:0] SEG1_START = SEG1_W'(10);
  localparam logic [SEG2_W-1:0] SEG2_START = SEG2_W'(5);
  localparam logic [SJW_W-1:0]  SJW_CODE   = SJW_W'(1);

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Request to the shared divider.
  typedef struct packed {
    logic              start;
    logic [CLK_W-1:0]  dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/cbts_div.sv
`include "assert_macros.svh"

module cbts_div (
  input  logic               clk,
  input  logic               rst,
  input  cbts_pkg::div_req_t req,
  output cbts_pkg::div_rsp_t rsp
);
  import cbts_pkg::*;

  localparam int DIV_STEPS = CLK_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  count;
  logic [RATE_W-1:0] rem;
  logic [CLK_W-1:0]  work;
  logic [RATE_W-1:0] dvs;

  logic [RATE_W:0]   trial;
  logic              fits;
  logic [RATE_W:0]   diff;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem, work[CLK_W-1]};
    fits  = (trial >= {1'b0, dvs});
    diff  = trial - {1'b0, dvs};
  end

  // One quotient bit per cycle, restoring form.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      // Flag the answer in the cycle after the last quotient step, with the final quotient.
      done <= busy && !req.start && (count == CNT_W'(DIV_STEPS - 1));
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        work  <= req.dividend;
        dvs   <= req.divisor;
      end else if (busy) begin
        rem  <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
        work <= {work[CLK_W-2:0], fits};
        if (count == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = work;

  `ASSERT_SAME(a_no_start_busy, clk, rst, req.start, !busy)
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_last_step_done, clk, rst,
               busy && !req.start && count == CNT_W'(DIV_STEPS - 1), done)

endmodule

// File: rtl/can_bit_timing_search.sv
// CAN bit timing search. Write the peripheral clock in hertz through
// cfg_write_en/cfg_write_data while the block is idle; then present one
// requested bit rate per word on the input channel. Each word returns one
// result word: status 0 with prescaler, jump width, segment one and segment
// two codes, or status 1 with all codes zero when the rate is outside
// 20000..1000000 or no exact setting exists. A rejected rate goes straight
// from idle to the emit state without the divider; a search tries up to
// fourteen segment pairs from the start pair down, on the single radix-2
// divider, which serves the cycles-per-bit division once and, at each pair,
// the prescaler division and, with the prescaler in range, the check. The input
// is not ready while a search runs; a finished result waits in the output
// register while the next word is taken.
`include "assert_macros.svh"

module can_bit_timing_search #(
  parameter int MAX_PRESCALER = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [27:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] target_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [9:0]  prescaler_code,
  output logic [1:0]  jump_width_code,
  output logic [3:0]  segment_one_code,
  output logic [2:0]  segment_two_code
);
  import cbts_pkg::*;

  localparam logic [CYC_W-1:0] PRESC_MAX = CYC_W'(MAX_PRESCALER);

  typedef enum logic [3:0] {
    IDLE,
    WAIT_CYC,
    START_PRE,
    WAIT_PRE,
    MUL,
    CHECK,
    WAIT_CHK,
    ADV,
    EMIT
  } state_t;

  state_t            state;
  logic [CLK_W-1:0]  peripheral_clock_hz;
  logic [RATE_W-1:0] rate;
  logic [CYC_W-1:0]  cycles;
  logic [CYC_W-1:0]  presc;
  logic [PROD_W-1:0] prod;
  logic              in_range;
  logic [SEG1_W-1:0] s1;
  logic [SEG2_W-1:0] s2;

  logic                    res_status;
  logic [PRESC_CODE_W-1:0] res_presc;
  logic [SJW_W-1:0]        res_sjw;
  logic [SEG1_W-1:0]       res_s1;
  logic [SEG2_W-1:0]       res_s2;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [QUANTA_W-1:0] quanta;
  logic [CYC_W-1:0]    presc_dec;
  logic [SEG1_W-1:0]   s1_next;
  logic [SEG2_W-1:0]   s2_next;
  logic                rate_bad;
  logic                out_free;

  cbts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Derive the step quantities from the current segment pair.
  always_comb begin
    quanta    = QUANTA_W'(1) + QUANTA_W'(s1) + QUANTA_W'(s2);
    presc_dec = presc - CYC_W'(1);
    rate_bad  = (target_rate < RATE_MIN) || (target_rate > RATE_MAX);
    out_free  = !out_valid || out_ready;
    s1_next   = s1;
    s2_next   = s2;
    if (s1 > SEG1_W'(s2)) begin
      s1_next = s1 - SEG1_W'(1);
    end else begin
      s2_next = s2 - SEG2_W'(1);
    end
  end

  assign in_ready = (state == IDLE);

  // Hold the clock register.
  always_ff @(posedge clk) begin
    if (rst) begin
      peripheral_clock_hz <= CLK_RESET;
    end else if (cfg_write_en) begin
      peripheral_clock_hz <= cfg_write_data;
    end
  end

  // Sequence the search and hold the output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      // Start the divider on entry to each wait state.
      div_req.start <= (state == IDLE && in_valid && !rate_bad) ||
                       (state == START_PRE) || (state == CHECK && in_range);
      // Load a new word or drop the one just taken.
      if (state == EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            rate <= target_rate;
            s1   <= SEG1_START;
            s2   <= SEG2_START;
            if (rate_bad) begin
              res_status <= STATUS_FAIL;
              res_presc  <= '0;
              res_sjw    <= '0;
              res_s1     <= '0;
              res_s2     <= '0;
              state      <= EMIT;
            end else begin
              div_req.dividend <= peripheral_clock_hz;
              div_req.divisor  <= target_rate;
              state            <= WAIT_CYC;
            end
          end
        end
        WAIT_CYC: begin
          if (div_rsp.done) begin
            cycles <= div_rsp.quotient[CYC_W-1:0];
            state  <= START_PRE;
          end
        end
        START_PRE: begin
          div_req.dividend <= CLK_W'(cycles);
          div_req.divisor  <= RATE_W'(quanta);
          state            <= WAIT_PRE;
        end
        WAIT_PRE: begin
          if (div_rsp.done) begin
            presc <= div_rsp.quotient[CYC_W-1:0];
            state <= MUL;
          end
        end
        MUL: begin
          prod     <= PROD_W'(presc) * PROD_W'(quanta);
          in_range <= (presc != '0) && (presc <= PRESC_MAX);
          state    <= CHECK;
        end
        CHECK: begin
          if (in_range) begin
            div_req.dividend <= peripheral_clock_hz;
            div_req.divisor  <= RATE_W'(prod);
            state            <= WAIT_CHK;
          end else begin
            state <= ADV;
          end
        end
        WAIT_CHK: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient == CLK_W'(rate)) begin
              res_status <= STATUS_OK;
              res_presc  <= presc_dec[PRESC_CODE_W-1:0];
              res_sjw    <= SJW_CODE;
              res_s1     <= s1 - SEG1_W'(1);
              res_s2     <= s2 - SEG2_W'(1);
              state      <= EMIT;
            end else begin
              state <= ADV;
            end
          end
        end
        ADV: begin
          s1 <= s1_next;
          s2 <= s2_next;
          if (s1_next == '0 || s2_next == '0) begin
            res_status <= STATUS_FAIL;
            res_presc  <= '0;
            res_sjw    <= '0;
            res_s1     <= '0;
            res_s2     <= '0;
            state      <= EMIT;
          end else begin
            state <= START_PRE;
          end
        end
        EMIT: begin
          if (out_free) begin
            status           <= res_status;
            prescaler_code   <= res_presc;
            jump_width_code  <= res_sjw;
            segment_one_code <= res_s1;
            segment_two_code <= res_s2;
            state            <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `ASSERT_SAME(a_fail_zero, clk, rst, out_valid && status == STATUS_FAIL,
               prescaler_code == '0 && jump_width_code == '0 &&
               segment_one_code == '0 && segment_two_code == '0)
  `ASSERT_SAME(a_ok_sjw, clk, rst, out_valid && status == STATUS_OK,
               jump_width_code == SJW_CODE)
  `ASSERT_SAME(a_start_wait, clk, rst, div_req.start,
               state == WAIT_CYC || state == WAIT_PRE || state == WAIT_CHK)

endmodule

// File: tb/can_bit_timing_search_tb.sv
`timescale 1ns / 100ps

module can_bit_timing_search_tb;
  import cbts_pkg::*;

  localparam int PRESC_LIMIT  = 1024;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 70;
  localparam int HOLD_CYCLES  = 2500;
  localparam int DRAIN_CYCLES = 1000;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic                    status;
    logic [PRESC_CODE_W-1:0] presc;
    logic [SJW_W-1:0]        sjw;
    logic [SEG1_W-1:0]       seg1;
    logic [SEG2_W-1:0]       seg2;
  } timing_t;

  typedef struct packed {
    logic [CLK_W-1:0]  clk_hz;
    logic [RATE_W-1:0] rate;
    logic              typed;
    timing_t           result;
  } rate_case_t;

  localparam timing_t REJECT = '{STATUS_FAIL, '0, '0, '0, '0};
  localparam timing_t UNSET  = '0;
  // 16 MHz at 1 Mbit/s: one quantum per clock, 16 quanta at the start pair
  localparam timing_t FAST_16M = '{STATUS_OK, 10'd0, SJW_CODE, 4'd9, 3'd4};

  localparam int NUM_CASES = 22;
  localparam rate_case_t RATE_CASES [NUM_CASES] = '{
    '{28'd42000000,  20'd0,       1'b1, REJECT},
    '{28'd42000000,  20'd19999,   1'b1, REJECT},
    '{28'd42000000,  20'd20000,   1'b0, UNSET},
    '{28'd42000000,  20'd500000,  1'b0, UNSET},
    '{28'd42000000,  20'd1000000, 1'b0, UNSET},
    '{28'd42000000,  20'd1000001, 1'b1, REJECT},
    '{28'd42000000,  20'hFFFFF,   1'b1, REJECT},
    '{28'd42000000,  20'd125000,  1'b0, UNSET},
    '{28'd42000000,  20'd999983,  1'b0, UNSET},
    '{28'd16000000,  20'd1000000, 1'b1, FAST_16M},
    '{28'd16000000,  20'd500000,  1'b0, UNSET},
    '{28'd0,         20'd250000,  1'b1, REJECT},
    '{28'd0,         20'd20000,   1'b1, REJECT},
    '{28'hFFFFFFF,   20'd20000,   1'b0, UNSET},
    '{28'hFFFFFFF,   20'd1000000, 1'b0, UNSET},
    '{28'd250000000, 20'd20000,   1'b0, UNSET},
    '{28'd250000000, 20'd20001,   1'b0, UNSET},
    '{28'd250000000, 20'd1000000, 1'b0, UNSET},
    '{28'd1000000,   20'd20000,   1'b0, UNSET},
    '{28'd1000000,   20'd500000,  1'b1, REJECT},
    '{28'd80000000,  20'd1000000, 1'b0, UNSET},
    '{28'd42000000,  20'd500000,  1'b0, UNSET}
  };

  localparam int unsigned COMMON_HZ [8] = '{
    8000000, 16000000, 24000000, 36000000, 42000000, 48000000, 64000000, 80000000
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write_en = 1'b0;
  logic [CLK_W-1:0]  cfg_write_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [RATE_W-1:0] target_rate = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              status;
  logic [9:0]        prescaler_code;
  logic [1:0]        jump_width_code;
  logic [3:0]        segment_one_code;
  logic [2:0]        segment_two_code;

  timing_t          pending_timings[$];
  logic [CLK_W-1:0] periph_hz = CLK_RESET;
  bit               quiet = 1'b0;
  bit               hold_req = 1'b0;
  bit               hold_taken = 1'b0;
  int               stall_left = 0;
  int               errors = 0;
  int               found_count = 0;
  int               rejected_count = 0;
  int               clock_writes = 0;
  int               cycle_count = 0;

  can_bit_timing_search #(
    .MAX_PRESCALER(PRESC_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .target_rate(target_rate),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .prescaler_code(prescaler_code),
    .jump_width_code(jump_width_code),
    .segment_one_code(segment_one_code),
    .segment_two_code(segment_two_code)
  );

  always #1 clk = ~clk;

  // Walk segment pairs down from the start pair until one divides the clock exactly
  function automatic timing_t search_bit_timing(logic [CLK_W-1:0] hz,
                                                logic [RATE_W-1:0] rate);
    timing_t         t;
    int unsigned     cyc;
    int unsigned     q;
    int unsigned     p;
    int unsigned     s1;
    int unsigned     s2;
    bit              found;
    longint unsigned span;
    t = REJECT;
    if (rate < RATE_MIN || rate > RATE_MAX) return t;
    cyc = hz / rate;
    s1 = SEG1_START;
    s2 = SEG2_START;
    found = 1'b0;
    while (!found && s1 != 0 && s2 != 0) begin
      q = 1 + s1 + s2;
      p = cyc / q;
      span = longint'(p) * q;
      if (p >= 1 && p <= PRESC_LIMIT && longint'(hz) / span == rate) begin
        found = 1'b1;
      end else if (s1 > s2) begin
        s1--;
      end else begin
        s2--;
      end
    end
    if (found) begin
      t.status = STATUS_OK;
      t.presc  = PRESC_CODE_W'(p - 1);
      t.sjw    = SJW_CODE;
      t.seg1   = SEG1_W'(s1 - 1);
      t.seg2   = SEG2_W'(s2 - 1);
    end
    return t;
  endfunction

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(1, 3);
    if (k < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Favor rates that some prescaler and segment pair hit exactly
  function automatic logic [RATE_W-1:0] next_rate(logic [CLK_W-1:0] hz);
    int              k;
    int unsigned     q;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned p;
    k = $urandom_range(0, 99);
    if (k < 55) begin
      q  = $urandom_range(3, 16);
      lo = (longint'(hz) + 64'd1000000 * q - 1) / (64'd1000000 * q);
      hi = longint'(hz) / (64'd20000 * q);
      if (lo < 1) lo = 1;
      if (hi > PRESC_LIMIT) hi = PRESC_LIMIT;
      if (lo <= hi) begin
        p = $urandom_range(int'(hi), int'(lo));
        return RATE_W'(longint'(hz) / (p * q));
      end
      return RATE_W'($urandom_range(RATE_MIN, RATE_MAX));
    end
    if (k < 75) return RATE_W'($urandom_range(RATE_MIN, RATE_MAX));
    if (k < 85) return RATE_W'($urandom);
    case ($urandom_range(0, 5))
      0: return RATE_MIN - RATE_W'(1);
      1: return RATE_MIN;
      2: return RATE_MIN + RATE_W'(1);
      3: return RATE_MAX - RATE_W'(1);
      4: return RATE_MAX;
      default: return RATE_MAX + RATE_W'(1);
    endcase
  endfunction

  function automatic logic [CLK_W-1:0] pick_clock(int phase);
    int k;
    if (phase == 0) return CLK_W'(250000000);
    if (phase == PHASES - 1) return CLK_W'(1000000);
    k = $urandom_range(0, 99);
    if (k < 60) return CLK_W'(COMMON_HZ[$urandom_range(0, 7)]);
    if (k < 85) return CLK_W'($urandom_range(1000000, 250000000));
    return CLK_W'($urandom);
  endfunction

  // Offer one word after an optional gap, hold it until taken, then log its timing
  task automatic send_rate(logic [RATE_W-1:0] rate, timing_t want);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 65) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    target_rate <= rate;
    do @(posedge clk); while (!in_ready);
    pending_timings.push_back(want);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_timings.size() != 0) @(negedge clk);
  endtask

  task automatic set_clock(logic [CLK_W-1:0] hz);
    settle_idle();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= hz;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    periph_hz = hz;
    clock_writes++;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      stall_left <= HOLD_CYCLES - 1;
      out_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= idle_len() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each taken result word against the oldest predicted timing
  always @(posedge clk) begin
    timing_t got;
    timing_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{status, prescaler_code, jump_width_code, segment_one_code, segment_two_code};
      if (got.status == STATUS_OK) found_count++;
      else rejected_count++;
      if (pending_timings.size() == 0) begin
        if (errors < REPORT_MAX)
          $display("%0t: result word with nothing expected: st=%0d presc=%0d sjw=%0d s1=%0d s2=%0d",
                   $realtime, got.status, got.presc, got.sjw, got.seg1, got.seg2);
        errors++;
      end else begin
        want = pending_timings.pop_front();
        if (got.status !== want.status || got.presc !== want.presc ||
            got.sjw !== want.sjw || got.seg1 !== want.seg1 || got.seg2 !== want.seg2) begin
          if (errors < REPORT_MAX)
            $display("%0t: timing mismatch exp st=%0d presc=%0d sjw=%0d s1=%0d s2=%0d, got st=%0d presc=%0d sjw=%0d s1=%0d s2=%0d",
                     $realtime, want.status, want.presc, want.sjw, want.seg1, want.seg2,
                     got.status, got.presc, got.sjw, got.seg1, got.seg2);
          errors++;
        end
      end
    end
  end

  // Bail out if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    timing_t          want;
    logic [RATE_W-1:0] rate;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed cases: range edges, clock extremes, known settings
    for (int i = 0; i < NUM_CASES; i++) begin
      if (RATE_CASES[i].clk_hz != periph_hz) set_clock(RATE_CASES[i].clk_hz);
      want = RATE_CASES[i].typed ? RATE_CASES[i].result
                                 : search_bit_timing(periph_hz, RATE_CASES[i].rate);
      send_rate(RATE_CASES[i].rate, want);
    end

    // Random phases, one clock setting each
    for (int phase = 0; phase < PHASES; phase++) begin
      set_clock(pick_clock(phase));
      quiet = (phase == 3);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 1 && n == 5) hold_req = 1'b1;
        if (phase == 5 && n == 35) settle_idle();
        rate = next_rate(periph_hz);
        send_rate(rate, search_bit_timing(periph_hz, rate));
      end
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d timing searches (%0d found, %0d rejected) over %0d clock writes",
             found_count + rejected_count, found_count, rejected_count, clock_writes);
    $display("Rates spanned both range edges, clocks from zero to full scale, %0d errors",
             errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
